// File: rtl/prime_count_sum_sieve_defines.svh
// Assertion macros for the prime counting sieve
`ifndef PRIME_COUNT_SUM_SIEVE_DEFINES_SVH
`define PRIME_COUNT_SUM_SIEVE_DEFINES_SVH

// Same-cycle implication, clocked on aclk, off during reset
`define PCS_CHECK(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pcs check failed");

// Next-cycle implication, clocked on aclk, off during reset
`define PCS_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pcs next-cycle check failed");

`endif

// File: rtl/pcs_pkg.sv
package pcs_pkg;

    localparam int unsigned MAX_ROOT = 1024;
    localparam int unsigned DEPTH    = 2 * MAX_ROOT;
    localparam int unsigned ADDR_W   = $clog2(DEPTH);
    localparam int unsigned SIZE_W   = ADDR_W + 1;
    localparam int unsigned ROOT_W   = $clog2(MAX_ROOT) + 1;
    localparam int unsigned VAL_W    = 21;
    localparam int unsigned SUM_W    = 30;
    localparam int unsigned STEP_W   = $clog2(VAL_W);

    localparam logic [VAL_W-1:0] LIMIT_CAP = VAL_W'(MAX_ROOT * (MAX_ROOT + 2));
    localparam logic [SUM_W-1:0] SUM_MOD   = 30'd715827883;

    localparam logic CMD_BUILD = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_UNBUILT = 2'd1,
        STATUS_RANGE   = 2'd2
    } status_t;

    typedef enum logic {
        ARITH_DIV    = 1'b0,
        ARITH_MODMUL = 1'b1
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } arith_stat_t;

    function automatic logic [SUM_W-1:0] sub_mod(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] t;
        if (a >= b) begin
            t = {1'b0, a} - {1'b0, b};
        end else begin
            t = {1'b0, a} + {1'b0, SUM_MOD} - {1'b0, b};
        end
        return t[SUM_W-1:0];
    endfunction

endpackage

// File: rtl/prime_count_sum_sieve.sv
// Prime counting and prime summing sieve over the quotient set of a limit N.
// Configuration: cfg_wr_en with cfg_wr_data writes the limit N at once; the
// new N takes effect at the next build command.
// Input beat (s_valid/s_ready): s_command 0 builds the tables, 1 queries
// s_query_value. s_ready is high only while no command is in progress.
// Result beat (m_valid/m_ready): m_prime_total, m_prime_sum_mod, m_status.
// Query: a rejected query or one below two goes straight to the result; one at
// most sqrt(N) reads its table entry directly; any other query first divides
// N by it on the 21-step shared divider. s_ready rises with m_valid. Build:
// the root is found by stepping, then each distinct quotient takes two divides
// and one modular multiply on the shared unit, then for each sieving prime p
// each updated table entry takes a modular multiply, and a divide where the
// multiple of p exceeds the root, on the shared divide/modular-multiply unit.
// One result beat per command. The finished result sits in an output
// register; a new command may be taken while it still waits.
// If the receiver stalls with a result pending, the next command completes
// and holds until the output register frees.
// Reset: the tables are unbuilt, queries report status 1, the limit is 1.
`include "prime_count_sum_sieve_defines.svh"
module prime_count_sum_sieve
    import pcs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [VAL_W-1:0]  cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_command,
    input  logic [VAL_W-1:0]  s_query_value,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [VAL_W-1:0]  m_prime_total,
    output logic [SUM_W-1:0]  m_prime_sum_mod,
    output logic [1:0]        m_status
);

    typedef enum logic [21:0] {
        ST_IDLE     = 22'h000001,
        ST_B_INIT   = 22'h000002,
        ST_B_ROOT   = 22'h000004,
        ST_B_QSTART = 22'h000008,
        ST_B_QDIV   = 22'h000010,
        ST_B_TRI    = 22'h000020,
        ST_B_LDIV   = 22'h000040,
        ST_S_PSTART = 22'h000080,
        ST_S_PI     = 22'h000100,
        ST_S_QI     = 22'h000200,
        ST_S_END    = 22'h000400,
        ST_S_KSTART = 22'h000800,
        ST_S_KRD    = 22'h001000,
        ST_S_KDIV   = 22'h002000,
        ST_S_SRC    = 22'h004000,
        ST_S_SDAT   = 22'h008000,
        ST_S_MM     = 22'h010000,
        ST_S_PNEXT  = 22'h020000,
        ST_Q_DIV    = 22'h040000,
        ST_Q_RD     = 22'h080000,
        ST_Q_DAT    = 22'h100000,
        ST_FIN      = 22'h200000
    } state_t;

    state_t            state_reg, state_next;
    logic              built_reg, built_next;
    logic [VAL_W-1:0]  ulim_reg;
    logic [VAL_W-1:0]  n_reg, n_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic              m_valid_reg;

    logic [VAL_W:0]    rsq_reg, rsq_next;
    logic [VAL_W-1:0]  left_reg, left_next;
    logic [VAL_W-1:0]  q_reg, q_next;
    logic [ROOT_W-1:0] p_reg, p_next;
    logic [VAL_W:0]    psq_reg, psq_next;
    logic [SIZE_W-1:0] k_reg, k_next;
    logic [SIZE_W-1:0] end_reg, end_next;
    logic [VAL_W:0]    kp_reg, kp_next;
    logic [VAL_W-1:0]  cnt0_reg, cnt0_next;
    logic [SUM_W-1:0]  sum0_reg, sum0_next;
    logic [VAL_W-1:0]  cntpi_reg, cntpi_next;
    logic [VAL_W-1:0]  cntk_reg, cntk_next;
    logic [SUM_W-1:0]  sumk_reg, sumk_next;
    logic [ADDR_W-1:0] src_reg, src_next;
    logic [ADDR_W-1:0] slot_reg, slot_next;
    logic [VAL_W-1:0]  rtot_reg, rtot_next;
    logic [SUM_W-1:0]  rsum_reg, rsum_next;
    status_t           rstat_reg, rstat_next;
    logic [VAL_W-1:0]  m_total_reg;
    logic [SUM_W-1:0]  m_sum_reg;
    logic [1:0]        m_status_reg;
    logic              m_load;

    logic [VAL_W-1:0]  quot_mem [DEPTH];
    logic [VAL_W-1:0]  cnt_mem  [DEPTH];
    logic [SUM_W-1:0]  sum_mem  [DEPTH];
    logic [VAL_W-1:0]  quot_rd;
    logic [VAL_W-1:0]  cnt_rd;
    logic [SUM_W-1:0]  sum_rd;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              quot_we;
    logic              cs_we;
    logic [VAL_W-1:0]  wr_quot;
    logic [VAL_W-1:0]  wr_cnt;
    logic [SUM_W-1:0]  wr_sum;

    arith_cmd_t        arith_cmd;
    arith_stat_t       arith_stat;
    logic [SUM_W-1:0]  arith_a;
    logic [VAL_W-1:0]  arith_b;
    logic [SUM_W-1:0]  arith_res;
    logic [VAL_W-1:0]  res_v;
    logic [VAL_W:0]    res_inc;

    pcs_arith u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (arith_cmd),
        .opa     (arith_a),
        .opb     (arith_b),
        .stat    (arith_stat),
        .result  (arith_res)
    );

    function automatic logic [ADDR_W-1:0] slot_small(input logic [ROOT_W-1:0] v,
                                                     input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] d;
        d = size - SIZE_W'(v);
        if (v == '0 || SIZE_W'(v) >= size) begin
            return '0;
        end
        return d[ADDR_W-1:0];
    endfunction

    assign res_v   = arith_res[VAL_W-1:0];
    assign res_inc = {1'b0, res_v} + 1'b1;
    assign m_load  = (state_reg == ST_FIN) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        built_next = built_reg;
        n_next     = n_reg;
        root_next  = root_reg;
        size_next  = size_reg;
        rsq_next   = rsq_reg;
        left_next  = left_reg;
        q_next     = q_reg;
        p_next     = p_reg;
        psq_next   = psq_reg;
        k_next     = k_reg;
        end_next   = end_reg;
        kp_next    = kp_reg;
        cnt0_next  = cnt0_reg;
        sum0_next  = sum0_reg;
        cntpi_next = cntpi_reg;
        cntk_next  = cntk_reg;
        sumk_next  = sumk_reg;
        src_next   = src_reg;
        slot_next  = slot_reg;
        rtot_next  = rtot_reg;
        rsum_next  = rsum_reg;
        rstat_next = rstat_reg;
        arith_cmd  = '{start: 1'b0, op: ARITH_DIV};
        arith_a    = '0;
        arith_b    = '0;
        rd_addr    = '0;
        wr_addr    = k_reg[ADDR_W-1:0];
        quot_we    = 1'b0;
        cs_we      = 1'b0;
        wr_quot    = q_reg;
        wr_cnt     = cntk_reg;
        wr_sum     = sub_mod(sumk_reg, arith_res);

        case (state_reg)
            ST_IDLE: begin
                rtot_next  = '0;
                rsum_next  = '0;
                rstat_next = STATUS_OK;
                if (s_valid) begin
                    if (s_command == CMD_BUILD) begin
                        state_next = ST_B_INIT;
                    end else if (!built_reg) begin
                        rstat_next = STATUS_UNBUILT;
                        state_next = ST_FIN;
                    end else if (s_query_value > n_reg) begin
                        rstat_next = STATUS_RANGE;
                        state_next = ST_FIN;
                    end else if (s_query_value < VAL_W'(2)) begin
                        state_next = ST_FIN;
                    end else if (s_query_value <= VAL_W'(root_reg)) begin
                        slot_next  = slot_small(s_query_value[ROOT_W-1:0], size_reg);
                        state_next = ST_Q_RD;
                    end else begin
                        arith_cmd  = '{start: 1'b1, op: ARITH_DIV};
                        arith_a    = SUM_W'(n_reg);
                        arith_b    = s_query_value;
                        state_next = ST_Q_DIV;
                    end
                end
            end
            ST_B_INIT: begin
                n_next     = (ulim_reg > LIMIT_CAP) ? LIMIT_CAP : ulim_reg;
                root_next  = '0;
                rsq_next   = (VAL_W+1)'(1);
                size_next  = '0;
                left_next  = VAL_W'(1);
                state_next = ST_B_ROOT;
            end
            ST_B_ROOT: begin
                if (rsq_reg <= {1'b0, n_reg}) begin
                    root_next = root_reg + 1'b1;
                    rsq_next  = rsq_reg + (VAL_W+1)'({root_reg, 1'b0}) + (VAL_W+1)'(3);
                end else begin
                    state_next = ST_B_QSTART;
                end
            end
            ST_B_QSTART: begin
                if (left_reg <= n_reg && size_reg < SIZE_W'(DEPTH)) begin
                    arith_cmd  = '{start: 1'b1, op: ARITH_DIV};
                    arith_a    = SUM_W'(n_reg);
                    arith_b    = left_reg;
                    state_next = ST_B_QDIV;
                end else begin
                    p_next     = ROOT_W'(2);
                    psq_next   = (VAL_W+1)'(4);
                    state_next = ST_S_PSTART;
                end
            end
            ST_B_QDIV: begin
                if (arith_stat.done) begin
                    q_next    = res_v;
                    arith_cmd = '{start: 1'b1, op: ARITH_MODMUL};
                    if (!res_v[0]) begin
                        arith_a = SUM_W'(res_v >> 1);
                        arith_b = res_inc[VAL_W-1:0];
                    end else begin
                        arith_a = SUM_W'(res_v);
                        arith_b = res_inc[VAL_W:1];
                    end
                    state_next = ST_B_TRI;
                end
            end
            ST_B_TRI: begin
                if (arith_stat.done) begin
                    quot_we    = 1'b1;
                    cs_we      = 1'b1;
                    wr_addr    = size_reg[ADDR_W-1:0];
                    wr_quot    = q_reg;
                    wr_cnt     = q_reg - 1'b1;
                    wr_sum     = sub_mod(arith_res, SUM_W'(1));
                    arith_cmd  = '{start: 1'b1, op: ARITH_DIV};
                    arith_a    = SUM_W'(n_reg);
                    arith_b    = q_reg;
                    state_next = ST_B_LDIV;
                end
            end
            ST_B_LDIV: begin
                if (arith_stat.done) begin
                    left_next  = res_inc[VAL_W-1:0];
                    size_next  = size_reg + 1'b1;
                    state_next = ST_B_QSTART;
                end
            end
            ST_S_PSTART: begin
                if (p_reg > root_reg) begin
                    built_next = 1'b1;
                    rtot_next  = '0;
                    rsum_next  = '0;
                    rstat_next = STATUS_OK;
                    state_next = ST_FIN;
                end else begin
                    rd_addr    = slot_small(p_reg, size_reg);
                    state_next = ST_S_PI;
                end
            end
            ST_S_PI: begin
                cntpi_next = cnt_rd;
                rd_addr    = slot_small(p_reg - 1'b1, size_reg);
                state_next = ST_S_QI;
            end
            ST_S_QI: begin
                if (cnt_rd == cntpi_reg) begin
                    state_next = ST_S_PNEXT;
                end else begin
                    cnt0_next = cnt_rd;
                    sum0_next = sum_rd;
                    k_next    = '0;
                    kp_next   = (VAL_W+1)'(p_reg);
                    if (psq_reg <= (VAL_W+1)'(root_reg)) begin
                        end_next   = size_reg - psq_reg[SIZE_W-1:0] + 1'b1;
                        state_next = ST_S_KSTART;
                    end else begin
                        arith_cmd  = '{start: 1'b1, op: ARITH_DIV};
                        arith_a    = SUM_W'(n_reg);
                        arith_b    = psq_reg[VAL_W-1:0];
                        state_next = ST_S_END;
                    end
                end
            end
            ST_S_END: begin
                if (arith_stat.done) begin
                    end_next   = (res_v > VAL_W'(size_reg)) ? size_reg : res_v[SIZE_W-1:0];
                    state_next = ST_S_KSTART;
                end
            end
            ST_S_KSTART: begin
                if (k_reg >= end_reg) begin
                    state_next = ST_S_PNEXT;
                end else begin
                    rd_addr    = k_reg[ADDR_W-1:0];
                    state_next = ST_S_KRD;
                end
            end
            ST_S_KRD: begin
                cntk_next = cnt_rd;
                sumk_next = sum_rd;
                if (kp_reg <= (VAL_W+1)'(root_reg)) begin
                    src_next   = ((kp_reg - 1'b1) < (VAL_W+1)'(size_reg))
                                 ? kp_reg[ADDR_W-1:0] - 1'b1 : '0;
                    state_next = ST_S_SRC;
                end else begin
                    arith_cmd  = '{start: 1'b1, op: ARITH_DIV};
                    arith_a    = SUM_W'(quot_rd);
                    arith_b    = VAL_W'(p_reg);
                    state_next = ST_S_KDIV;
                end
            end
            ST_S_KDIV: begin
                if (arith_stat.done) begin
                    if (res_v == '0 || res_v > VAL_W'(size_reg)) begin
                        src_next = '0;
                    end else begin
                        src_next = ADDR_W'(size_reg - res_v[SIZE_W-1:0]);
                    end
                    state_next = ST_S_SRC;
                end
            end
            ST_S_SRC: begin
                rd_addr    = src_reg;
                state_next = ST_S_SDAT;
            end
            ST_S_SDAT: begin
                cntk_next  = cntk_reg - (cnt_rd - cnt0_reg);
                arith_cmd  = '{start: 1'b1, op: ARITH_MODMUL};
                arith_a    = sub_mod(sum_rd, sum0_reg);
                arith_b    = VAL_W'(p_reg);
                state_next = ST_S_MM;
            end
            ST_S_MM: begin
                if (arith_stat.done) begin
                    cs_we      = 1'b1;
                    k_next     = k_reg + 1'b1;
                    kp_next    = kp_reg + (VAL_W+1)'(p_reg);
                    state_next = ST_S_KSTART;
                end
            end
            ST_S_PNEXT: begin
                psq_next   = psq_reg + (VAL_W+1)'({p_reg, 1'b0}) + 1'b1;
                p_next     = p_reg + 1'b1;
                state_next = ST_S_PSTART;
            end
            ST_Q_DIV: begin
                if (arith_stat.done) begin
                    slot_next  = ((res_v - 1'b1) >= VAL_W'(size_reg))
                                 ? '0 : ADDR_W'(res_v - 1'b1);
                    state_next = ST_Q_RD;
                end
            end
            ST_Q_RD: begin
                rd_addr    = slot_reg;
                state_next = ST_Q_DAT;
            end
            ST_Q_DAT: begin
                rtot_next  = cnt_rd;
                rsum_next  = sum_rd;
                rstat_next = STATUS_OK;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (m_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            built_reg   <= 1'b0;
            ulim_reg    <= VAL_W'(1);
            n_reg       <= '0;
            root_reg    <= '0;
            size_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            built_reg <= built_next;
            n_reg     <= n_next;
            root_reg  <= root_next;
            size_reg  <= size_next;
            if (cfg_wr_en) begin
                ulim_reg <= cfg_wr_data;
            end
            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rsq_reg   <= rsq_next;
        left_reg  <= left_next;
        q_reg     <= q_next;
        p_reg     <= p_next;
        psq_reg   <= psq_next;
        k_reg     <= k_next;
        end_reg   <= end_next;
        kp_reg    <= kp_next;
        cnt0_reg  <= cnt0_next;
        sum0_reg  <= sum0_next;
        cntpi_reg <= cntpi_next;
        cntk_reg  <= cntk_next;
        sumk_reg  <= sumk_next;
        src_reg   <= src_next;
        slot_reg  <= slot_next;
        rtot_reg  <= rtot_next;
        rsum_reg  <= rsum_next;
        rstat_reg <= rstat_next;
        if (m_load) begin
            m_total_reg  <= rtot_reg;
            m_sum_reg    <= rsum_reg;
            m_status_reg <= rstat_reg;
        end
    end

    always_ff @(posedge aclk) begin
        quot_rd <= quot_mem[rd_addr];
        cnt_rd  <= cnt_mem[rd_addr];
        sum_rd  <= sum_mem[rd_addr];
        if (quot_we) begin
            quot_mem[wr_addr] <= wr_quot;
        end
        if (cs_we) begin
            cnt_mem[wr_addr] <= wr_cnt;
            sum_mem[wr_addr] <= wr_sum;
        end
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_prime_total   = m_total_reg;
    assign m_prime_sum_mod = m_sum_reg;
    assign m_status        = m_status_reg;

    `PCS_CHECK(a_idle_unit_quiet, state_reg == ST_IDLE, !arith_stat.busy)
    `PCS_CHECK(a_size_cap, built_reg, size_reg <= SIZE_W'(DEPTH))
    `PCS_CHECK(a_flag_zero, m_valid && m_status != STATUS_OK, m_prime_total == '0 && m_prime_sum_mod == '0)
    `PCS_CHECK_NEXT(a_accept_busy, s_valid && s_ready, !s_ready)

endmodule

// File: rtl/pcs_arith.sv
module pcs_arith
    import pcs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  arith_cmd_t        cmd,
    input  logic [SUM_W-1:0]  opa,
    input  logic [VAL_W-1:0]  opb,
    output arith_stat_t       stat,
    output logic [SUM_W-1:0]  result
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    arith_op_t         op_reg;
    logic [STEP_W-1:0] step_reg;
    logic [VAL_W:0]    rem_reg;
    logic [VAL_W-1:0]  quo_reg;
    logic [VAL_W-1:0]  div_reg;
    logic [SUM_W-1:0]  x_reg;
    logic [VAL_W-1:0]  y_reg;
    logic [SUM_W-1:0]  acc_reg;

    logic              load;
    logic [VAL_W:0]    rem_sh;
    logic              fits;
    logic [VAL_W:0]    rem_new;
    logic [SUM_W:0]    dbl;
    logic [SUM_W:0]    dbl_red;
    logic [SUM_W:0]    sum_raw;
    logic [SUM_W-1:0]  acc_new;

    assign load = cmd.start && !busy_reg;

    always_comb begin
        rem_sh  = {rem_reg[VAL_W-1:0], quo_reg[VAL_W-1]};
        fits    = rem_sh >= {1'b0, div_reg};
        rem_new = fits ? (rem_sh - {1'b0, div_reg}) : rem_sh;

        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, SUM_MOD}) ? (dbl - {1'b0, SUM_MOD}) : dbl;
        sum_raw = dbl_red + (y_reg[VAL_W-1] ? {1'b0, x_reg} : '0);
        acc_new = (sum_raw >= {1'b0, SUM_MOD}) ? SUM_W'(sum_raw - {1'b0, SUM_MOD})
                                               : sum_raw[SUM_W-1:0];
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        if (load) begin
            busy_next = 1'b1;
        end else if (busy_reg && step_reg == '0) begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            op_reg   <= cmd.op;
            step_reg <= STEP_W'(VAL_W - 1);
            rem_reg  <= '0;
            quo_reg  <= opa[VAL_W-1:0];
            div_reg  <= opb;
            x_reg    <= opa;
            y_reg    <= opb;
            acc_reg  <= '0;
        end else if (busy_reg) begin
            step_reg <= step_reg - 1'b1;
            if (op_reg == ARITH_DIV) begin
                rem_reg <= rem_new;
                quo_reg <= {quo_reg[VAL_W-2:0], fits};
            end else begin
                acc_reg <= acc_new;
                y_reg   <= {y_reg[VAL_W-2:0], 1'b0};
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = (op_reg == ARITH_DIV) ? {{(SUM_W-VAL_W){1'b0}}, quo_reg} : acc_reg;

endmodule

// File: bench/tb_prime_count_sum_sieve.sv
module tb_prime_count_sum_sieve;
    import pcs_pkg::*;

    localparam longint unsigned MODV = 64'(SUM_MOD);
    localparam int WATCH_LIMIT = 4_000_000;

    typedef struct {
        logic             cmd;
        logic [VAL_W-1:0] value;
    } command_t;

    typedef struct {
        logic [VAL_W-1:0] total;
        logic [SUM_W-1:0] sum;
        status_t          status;
    } answer_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [VAL_W-1:0] cfg_wr_data = '0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic             s_command = CMD_BUILD;
    logic [VAL_W-1:0] s_query_value = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [VAL_W-1:0] m_prime_total;
    logic [SUM_W-1:0] m_prime_sum_mod;
    logic [1:0]       m_status;

    command_t pending_cmds[$];
    answer_t  expected_answers[$];
    int       fail_count = 0;
    int       send_idle = 29;
    int       recv_idle = 85;
    logic     hold_go = 1'b0;
    logic     hold_seen = 1'b0;
    int       hold_cnt = 0;
    int       quiet_cycles = 0;

    // predictor state
    int unsigned quot_tab[DEPTH];
    int unsigned cnt_tab[DEPTH];
    int unsigned sum_tab[DEPTH];
    longint unsigned root_val = 0;
    longint unsigned tab_size = 0;
    bit              tables_built = 0;
    longint unsigned built_n = 0;
    longint unsigned limit_shadow = 1;

    prime_count_sum_sieve dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_command(s_command), .s_query_value(s_query_value),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_prime_total(m_prime_total), .m_prime_sum_mod(m_prime_sum_mod),
        .m_status(m_status)
    );

    always #2 aclk = ~aclk;

    function automatic longint unsigned less_mod(longint unsigned a, longint unsigned b);
        return (a >= b) ? a - b : a + MODV - b;
    endfunction

    function automatic longint unsigned triangle_mod(longint unsigned v);
        longint unsigned a, b;
        a = v;
        b = v + 1;
        if (a[0] == 1'b0) a = a / 2; else b = b / 2;
        return ((a % MODV) * (b % MODV)) % MODV;
    endfunction

    function automatic longint unsigned slot_for(longint unsigned v);
        longint unsigned s;
        if (v == 0) return 0;
        if (v <= root_val) s = tab_size - v;
        else s = built_n / v - 1;
        if (s >= tab_size || s >= DEPTH) s = 0;
        return s;
    endfunction

    function automatic void sieve_tables();
        longint unsigned n, r, left, q, p, sq, fin, k, src, diff, removed;
        longint unsigned pi, qi;
        int unsigned c0, s0;
        n = limit_shadow;
        r = 0;
        if (n > 64'(LIMIT_CAP)) n = 64'(LIMIT_CAP);
        built_n = n;
        while ((r + 1) * (r + 1) <= n) r++;
        root_val = r;
        tab_size = 0;
        left = 1;
        while (left <= n && tab_size < DEPTH) begin
            q = n / left;
            quot_tab[tab_size] = q;
            tab_size++;
            left = n / q + 1;
        end
        for (int i = 0; i < tab_size; i++) begin
            cnt_tab[i] = quot_tab[i] - 1;
            sum_tab[i] = less_mod(triangle_mod(quot_tab[i]), 1);
        end
        for (p = 2; p <= r; p++) begin
            pi = slot_for(p);
            qi = slot_for(p - 1);
            if (cnt_tab[pi] == cnt_tab[qi]) continue;
            c0 = cnt_tab[qi];
            s0 = sum_tab[qi];
            sq = p * p;
            fin = (sq <= r) ? tab_size - sq + 1 : n / sq;
            if (fin > tab_size) fin = tab_size;
            for (k = 0; k < fin; k++) begin
                if ((k + 1) * p <= r) src = (k + 1) * p - 1;
                else src = tab_size - quot_tab[k] / p;
                if (src >= tab_size) src = 0;
                cnt_tab[k] = cnt_tab[k] - (cnt_tab[src] - c0);
                diff = less_mod(sum_tab[src], s0);
                removed = ((p % MODV) * diff) % MODV;
                sum_tab[k] = less_mod(sum_tab[k], removed);
            end
        end
        tables_built = 1;
    endfunction

    function automatic answer_t predict_answer(command_t c);
        answer_t a;
        longint unsigned s;
        a.total = '0;
        a.sum = '0;
        a.status = STATUS_OK;
        if (c.cmd == CMD_BUILD) begin
            sieve_tables();
        end else if (!tables_built) begin
            a.status = STATUS_UNBUILT;
        end else if (c.value > built_n) begin
            a.status = STATUS_RANGE;
        end else if (c.value >= 2) begin
            s = slot_for(c.value);
            a.total = cnt_tab[s][VAL_W-1:0];
            a.sum = sum_tab[s][SUM_W-1:0];
        end
        return a;
    endfunction

    task automatic report(string field, longint unsigned got, longint unsigned want);
        $display("mismatch %s: got %0d expected %0d", field, got, want);
        fail_count++;
    endtask

    // driver
    always @(posedge aclk) begin
        command_t c;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                c.cmd = s_command;
                c.value = s_query_value;
                expected_answers.insert(expected_answers.size(), predict_answer(c));
            end
            if (!s_valid || s_ready) begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle) begin
                    c = pending_cmds.pop_front();
                    s_valid <= 1'b1;
                    s_command <= c.cmd;
                    s_query_value <= c.value;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        answer_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_answers.size() == 0) begin
                    report("unexpected beat", m_status, 0);
                end else begin
                    e = expected_answers.pop_front();
                    if (m_prime_total !== e.total) report("prime_total", m_prime_total, e.total);
                    if (m_prime_sum_mod !== e.sum) report("prime_sum_mod", m_prime_sum_mod, e.sum);
                    if (m_status !== e.status) report("status", m_status, e.status);
                end
            end
            if (hold_go != hold_seen) begin
                hold_seen <= hold_go;
                hold_cnt <= 400;
                m_ready <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic add_cmd(logic cmd, logic [VAL_W-1:0] value);
        command_t c;
        c.cmd = cmd;
        c.value = value;
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    task automatic drain();
        while (pending_cmds.size() > 0 || s_valid || expected_answers.size() > 0)
            @(negedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic set_limit(logic [VAL_W-1:0] n);
        drain();
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= n;
        limit_shadow = n;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic query_set(int n);
        add_cmd(CMD_QUERY, 0);
        add_cmd(CMD_QUERY, 1);
        add_cmd(CMD_QUERY, 2);
        add_cmd(CMD_QUERY, n);
        add_cmd(CMD_QUERY, n + 1);
    endtask

    initial begin
        int n, v;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed
        add_cmd(CMD_QUERY, 5);
        add_cmd(CMD_QUERY, '1);
        add_cmd(CMD_BUILD, '1);
        query_set(1);
        set_limit(0);
        add_cmd(CMD_BUILD, 0);
        query_set(0);
        set_limit(100);
        add_cmd(CMD_BUILD, 0);
        query_set(100);
        add_cmd(CMD_QUERY, 3);
        add_cmd(CMD_QUERY, 97);
        set_limit(1050624);
        add_cmd(CMD_QUERY, 100);
        add_cmd(CMD_QUERY, 101);
        add_cmd(CMD_QUERY, 1050624);
        set_limit(20000);
        add_cmd(CMD_BUILD, 0);
        add_cmd(CMD_QUERY, 19999);
        add_cmd(CMD_QUERY, 20000);
        add_cmd(CMD_QUERY, 141);
        add_cmd(CMD_QUERY, 142);

        // random
        for (int ph = 0; ph < 8; ph++) begin
            n = (ph == 7) ? 4 : $urandom_range(2, 4000);
            set_limit(n);
            send_idle = (ph < 3) ? 29 : (ph < 6) ? 85 : 0;
            recv_idle = (ph < 3) ? 85 : (ph < 6) ? 29 : 0;
            add_cmd(CMD_BUILD, $urandom);
            for (int i = 0; i < 250; i++) begin
                v = $urandom_range(99);
                if (v < 90) add_cmd(CMD_QUERY, $urandom_range(0, n));
                else if (v < 99) add_cmd(CMD_QUERY, $urandom);
                else add_cmd(CMD_BUILD, $urandom);
            end
            if (ph == 6) begin
                while (pending_cmds.size() > 200) @(posedge aclk);
                hold_go <= ~hold_go;
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
